// ----- rtl/button_press_classifier_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the button press classifier
// Shared concurrent assertion forms with a synchronous active-high reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Button press classifier package
// Payload types, phase and event codes, and register indexes.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Input transfer payload.
  typedef struct packed {
    logic        mode;
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  // Result transfer payload.
  typedef struct packed {
    logic [1:0] press_event;
    logic       evaluating;
  } out_t;

  // Item kinds.
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Analysis phases.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_RELEASED = 2'd2;
  localparam logic [1:0] PH_DCHECK   = 2'd3;

  // Press event codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [2:0] REG_SHORT_PRESS   = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS    = 3'd2;
  localparam logic [2:0] REG_DOUBLE_WIN    = 3'd3;
  localparam logic [2:0] REG_PRESSED_LEVEL = 3'd4;

  // Saturation limit of the short press count.
  localparam logic [1:0] SHORT_COUNT_MAX = 2'd3;

endpackage

// ----- rtl/button_press_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Button press classifier core
// Debounces button edges and classifies presses as single, double or long.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries two kinds of item with a millisecond timestamp:
// pin edges (mode 0, with the sampled pin level) and periodic evaluate ticks
// (mode 1). Every accepted item yields exactly one result on the output
// channel: a press event code and the evaluating flag, which is high while
// the press timer runs and the sender should keep issuing evaluate ticks.
// An accepted item is held in the input register; the state update and the
// result register load from it as it moves on, and the result is then
// offered on the output channel. Throughput is one item per clock while
// the receiver does not stall; the input register and the result register
// are separate stages, so an item is taken while a finished result still
// waits. When the receiver stalls, the result register holds, the input
// register fills, and in_ready falls until the result is taken.
// Reset clears both stages, the analysis state and all timestamps, and
// loads the register defaults (debounce 50, short 300, long 1000, double
// window 300, pressed level low). The user must write registers through the
// APB port only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module button_press_classifier_core (
  input  logic              clk,
  input  logic              rst,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  bpc_pkg::in_t      in_data,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output bpc_pkg::out_t     out_data,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  `include "button_press_classifier_core_assert.svh"

  // Configuration registers
  logic [15:0] debounce_ms;
  logic [15:0] short_press_ms;
  logic [15:0] long_press_ms;
  logic [15:0] double_window_ms;
  logic        pressed_level;

  // Analysis state
  logic [1:0]  phase;
  logic [31:0] press_time;
  logic [31:0] release_time;
  logic [31:0] last_edge_time;
  logic [1:0]  short_count;
  logic        timer_on;

  // Pipeline stages
  logic          s1_valid;
  bpc_pkg::in_t  s1_data;

  // Next-state values
  logic [1:0]  phase_next;
  logic [31:0] press_time_next;
  logic [31:0] release_time_next;
  logic [31:0] last_edge_time_next;
  logic [1:0]  short_count_next;
  logic        timer_on_next;
  logic [1:0]  event_next;

  logic        s1_advance;
  logic        cfg_write;
  logic [2:0]  reg_index;

  // Elapsed-time differences, all modulo 2^32
  logic [31:0] edge_age;
  logic [31:0] press_age;
  logic [31:0] press_len;
  logic [31:0] release_age;

  // Configuration write and read
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= 16'd50;
      short_press_ms   <= 16'd300;
      long_press_ms    <= 16'd1000;
      double_window_ms <= 16'd300;
      pressed_level    <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        bpc_pkg::REG_DEBOUNCE:      debounce_ms      <= pwdata[15:0];
        bpc_pkg::REG_SHORT_PRESS:   short_press_ms   <= pwdata[15:0];
        bpc_pkg::REG_LONG_PRESS:    long_press_ms    <= pwdata[15:0];
        bpc_pkg::REG_DOUBLE_WIN:    double_window_ms <= pwdata[15:0];
        bpc_pkg::REG_PRESSED_LEVEL: pressed_level    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      bpc_pkg::REG_DEBOUNCE:      prdata = {16'd0, debounce_ms};
      bpc_pkg::REG_SHORT_PRESS:   prdata = {16'd0, short_press_ms};
      bpc_pkg::REG_LONG_PRESS:    prdata = {16'd0, long_press_ms};
      bpc_pkg::REG_DOUBLE_WIN:    prdata = {16'd0, double_window_ms};
      bpc_pkg::REG_PRESSED_LEVEL: prdata = {31'd0, pressed_level};
      default:                    prdata = 32'd0;
    endcase
  end

  // Stage handshake: the input register moves on whenever the result
  // register is empty or its transfer completes this cycle.
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Time differences for the item in the input register.
  assign edge_age    = s1_data.now_ms - last_edge_time;
  assign press_age   = s1_data.now_ms - press_time;
  assign press_len   = release_time - press_time;
  assign release_age = s1_data.now_ms - release_time;

  // Classification logic for one item.
  always_comb begin
    phase_next          = phase;
    press_time_next     = press_time;
    release_time_next   = release_time;
    last_edge_time_next = last_edge_time;
    short_count_next    = short_count;
    timer_on_next       = timer_on;
    event_next          = bpc_pkg::EV_NONE;

    if (s1_data.mode == bpc_pkg::MODE_EDGE) begin
      // A debounced edge records its time; a press also starts the timer.
      if (edge_age > {16'd0, debounce_ms}) begin
        if (s1_data.pin_level == pressed_level) begin
          timer_on_next   = 1'b1;
          press_time_next = s1_data.now_ms;
          phase_next      = bpc_pkg::PH_PRESSED;
        end else begin
          release_time_next = s1_data.now_ms;
          phase_next        = bpc_pkg::PH_RELEASED;
        end
        last_edge_time_next = s1_data.now_ms;
      end
    end else if (timer_on) begin
      case (phase)
        bpc_pkg::PH_RELEASED: begin
          if (press_age > {16'd0, long_press_ms}) begin
            event_next       = bpc_pkg::EV_LONG;
            phase_next       = bpc_pkg::PH_IDLE;
            timer_on_next    = 1'b0;
            short_count_next = 2'd0;
          end else if (press_len <= {16'd0, short_press_ms}) begin
            if (short_count != bpc_pkg::SHORT_COUNT_MAX) begin
              short_count_next = short_count + 2'd1;
            end
            phase_next = bpc_pkg::PH_DCHECK;
          end else begin
            event_next       = bpc_pkg::EV_SINGLE;
            phase_next       = bpc_pkg::PH_IDLE;
            timer_on_next    = 1'b0;
            short_count_next = 2'd0;
          end
        end
        bpc_pkg::PH_DCHECK: begin
          // After the double-press window the count picks the event.
          if (release_age > {16'd0, double_window_ms}) begin
            if (short_count == 2'd1) begin
              event_next = bpc_pkg::EV_SINGLE;
            end else if (short_count == 2'd2) begin
              event_next = bpc_pkg::EV_DOUBLE;
            end
            phase_next       = bpc_pkg::PH_IDLE;
            timer_on_next    = 1'b0;
            short_count_next = 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // State update, once per item as it leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= bpc_pkg::PH_IDLE;
      press_time     <= 32'd0;
      release_time   <= 32'd0;
      last_edge_time <= 32'd0;
      short_count    <= 2'd0;
      timer_on       <= 1'b0;
    end else if (s1_valid && s1_advance) begin
      phase          <= phase_next;
      press_time     <= press_time_next;
      release_time   <= release_time_next;
      last_edge_time <= last_edge_time_next;
      short_count    <= short_count_next;
      timer_on       <= timer_on_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      out_data.press_event <= event_next;
      out_data.evaluating  <= timer_on_next;
    end
  end

  // Assertions
  `BPC_ASSERT_IMPL(a_event_ends_timer, clk, rst,
    out_valid && (out_data.press_event != bpc_pkg::EV_NONE),
    !out_data.evaluating, "press event reported while timer still running")
  `BPC_ASSERT_IMPL(a_count_needs_timer, clk, rst,
    !timer_on, short_count == 2'd0, "short press count nonzero with timer stopped")
  `BPC_ASSERT_IMPL(a_dcheck_needs_timer, clk, rst,
    phase == bpc_pkg::PH_DCHECK, timer_on, "double check phase with timer stopped")
  `BPC_ASSERT_NEXT(a_stage_fill, clk, rst,
    in_valid && in_ready, s1_valid, "accepted transfer missing from input register")

endmodule

// ----- tb/tb_button_press_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Testbench for the button press classifier core
// Sends pin edge and evaluate items with millisecond timestamps, predicts
// each result with a cycle-free model of the debounce and press analysis,
// and checks every result transfer against it. Runs directed press gestures
// first, then random gestures and noise over several register settings,
// with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_button_press_classifier_core;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEMS_PER_PHASE = 255;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  bpc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  bpc_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Items waiting to be sent and results predicted for accepted items.
  bpc_pkg::in_t  press_items[$];
  bpc_pkg::out_t predicted_reports[$];
  int            awaiting_results = 0;
  int            error_count = 0;
  int            cycle_count = 0;
  int            burst_left = 0;
  int            gap_left = 0;
  bpc_pkg::out_t wanted;

  // Register copies used by the predictor and the stimulus generator.
  logic [15:0] cfg_debounce = 16'd50;
  logic [15:0] cfg_short = 16'd300;
  logic [15:0] cfg_long = 16'd1000;
  logic [15:0] cfg_window = 16'd300;
  logic        cfg_active = 1'b0;

  // Predicted analysis state.
  logic [1:0]  analysis_phase = bpc_pkg::PH_IDLE;
  logic [31:0] press_at = '0;
  logic [31:0] release_at = '0;
  logic [31:0] last_edge_at = '0;
  logic [1:0]  short_taps = '0;
  logic        timing_on = 1'b0;

  // Timestamp cursor for generated gestures.
  logic [31:0] stamp_now = 32'h0000_0200;

  button_press_classifier_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A finished analysis returns to idle with the timer stopped.
  function automatic void end_analysis();
    analysis_phase = bpc_pkg::PH_IDLE;
    timing_on = 1'b0;
    short_taps = '0;
  endfunction

  // Predicts the result of one item and advances the analysis state.
  function automatic bpc_pkg::out_t classify_press(bpc_pkg::in_t item);
    bpc_pkg::out_t res;
    logic [31:0]   since_edge;
    logic [31:0]   since_press;
    logic [31:0]   held_for;
    logic [31:0]   since_release;
    since_edge = item.now_ms - last_edge_at;
    since_press = item.now_ms - press_at;
    held_for = release_at - press_at;
    since_release = item.now_ms - release_at;
    res.press_event = bpc_pkg::EV_NONE;
    if (item.mode == bpc_pkg::MODE_EDGE) begin
      // Edges no further than the debounce time from the last accepted one are dropped.
      if (since_edge > {16'd0, cfg_debounce}) begin
        if (item.pin_level == cfg_active) begin
          timing_on = 1'b1;
          press_at = item.now_ms;
          analysis_phase = bpc_pkg::PH_PRESSED;
        end else begin
          release_at = item.now_ms;
          analysis_phase = bpc_pkg::PH_RELEASED;
        end
        last_edge_at = item.now_ms;
      end
    end else if (timing_on) begin
      if (analysis_phase == bpc_pkg::PH_RELEASED) begin
        if (since_press > {16'd0, cfg_long}) begin
          res.press_event = bpc_pkg::EV_LONG;
          end_analysis();
        end else if (held_for <= {16'd0, cfg_short}) begin
          if (short_taps != bpc_pkg::SHORT_COUNT_MAX) begin
            short_taps = short_taps + 2'd1;
          end
          analysis_phase = bpc_pkg::PH_DCHECK;
        end else begin
          res.press_event = bpc_pkg::EV_SINGLE;
          end_analysis();
        end
      end else if (analysis_phase == bpc_pkg::PH_DCHECK) begin
        // After the window the tap count decides; three or more gives nothing.
        if (since_release > {16'd0, cfg_window}) begin
          if (short_taps == 2'd1) begin
            res.press_event = bpc_pkg::EV_SINGLE;
          end else if (short_taps == 2'd2) begin
            res.press_event = bpc_pkg::EV_DOUBLE;
          end
          end_analysis();
        end
      end
    end
    res.evaluating = timing_on;
    return res;
  endfunction

  task automatic add_item(input logic kind, input logic level, input logic [31:0] stamp);
    bpc_pkg::in_t item;
    item.mode = kind;
    item.pin_level = level;
    item.now_ms = stamp;
    press_items.push_back(item);
    awaiting_results++;
  endtask

  // One well-formed gesture: one to four presses with evaluate ticks around them.
  task automatic add_gesture();
    int unsigned taps;
    int unsigned hold;
    int unsigned step;
    int unsigned ticks;
    logic        act;
    act = cfg_active;
    taps = $urandom_range(1, 4);
    for (int t = 0; t < taps; t++) begin
      stamp_now += cfg_debounce + 1 + $urandom_range(0, 40);
      add_item(bpc_pkg::MODE_EDGE, act, stamp_now);
      // Occasional contact bounce inside the debounce time.
      if ($urandom_range(0, 3) == 0) begin
        add_item(bpc_pkg::MODE_EDGE, !act, stamp_now + $urandom_range(0, cfg_debounce));
      end
      case ($urandom_range(0, 3))
        0: hold = $urandom_range(0, cfg_short);
        1: hold = cfg_short + $urandom_range(0, 1);
        2: hold = cfg_short + 1 + $urandom_range(0, cfg_long);
        default: hold = cfg_long + $urandom_range(0, 2);
      endcase
      if ($urandom_range(0, 7) != 0 && hold <= cfg_debounce) begin
        hold = cfg_debounce + 1;
      end
      if ($urandom_range(0, 1) == 1) begin
        add_item(bpc_pkg::MODE_EVAL, 1'($urandom_range(0, 1)),
                 stamp_now + $urandom_range(0, hold));
      end
      stamp_now += hold;
      add_item(bpc_pkg::MODE_EDGE, !act, stamp_now);
      add_item(bpc_pkg::MODE_EVAL, 1'($urandom_range(0, 1)),
               stamp_now + $urandom_range(0, 2));
    end
    // Ticks that run out the double-press window, sometimes right at its boundary.
    if ($urandom_range(0, 1) == 1) begin
      add_item(bpc_pkg::MODE_EVAL, 1'($urandom_range(0, 1)), stamp_now + cfg_window);
      stamp_now += cfg_window + 1;
      add_item(bpc_pkg::MODE_EVAL, 1'($urandom_range(0, 1)), stamp_now);
    end else begin
      step = cfg_window / 3 + 1;
      ticks = $urandom_range(1, 5);
      for (int k = 0; k < ticks; k++) begin
        stamp_now += step + $urandom_range(0, 1);
        add_item(bpc_pkg::MODE_EVAL, 1'($urandom_range(0, 1)), stamp_now);
      end
    end
  endtask

  // Stray items: random times, idle ticks, bounces and jumps of the clock.
  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: add_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      1: begin
        stamp_now += $urandom_range(0, 100);
        add_item(bpc_pkg::MODE_EVAL, 1'($urandom_range(0, 1)), stamp_now);
      end
      2: add_item(bpc_pkg::MODE_EDGE, 1'($urandom_range(0, 1)),
                  stamp_now + $urandom_range(0, cfg_debounce));
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          stamp_now = $urandom;
        end else begin
          stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 70000);
        end
      end
    endcase
  endtask

  task automatic fill_random(input int count);
    int target;
    target = awaiting_results + count;
    while (awaiting_results < target) begin
      if ($urandom_range(0, 9) < 7) begin
        add_gesture();
      end else begin
        add_noise();
      end
    end
  endtask

  // Waits until every item has been sent and its result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (awaiting_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      bpc_pkg::REG_DEBOUNCE:      cfg_debounce = value[15:0];
      bpc_pkg::REG_SHORT_PRESS:   cfg_short = value[15:0];
      bpc_pkg::REG_LONG_PRESS:    cfg_long = value[15:0];
      bpc_pkg::REG_DOUBLE_WIN:    cfg_window = value[15:0];
      bpc_pkg::REG_PRESSED_LEVEL: cfg_active = value[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] debounce, input logic [15:0] short_ms,
                               input logic [15:0] long_ms, input logic [15:0] window,
                               input logic active);
    apb_write(bpc_pkg::REG_DEBOUNCE, {16'd0, debounce});
    apb_write(bpc_pkg::REG_SHORT_PRESS, {16'd0, short_ms});
    apb_write(bpc_pkg::REG_LONG_PRESS, {16'd0, long_ms});
    apb_write(bpc_pkg::REG_DOUBLE_WIN, {16'd0, window});
    apb_write(bpc_pkg::REG_PRESSED_LEVEL, {31'd0, active});
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_reports.push_back(classify_press(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (press_items.size() > 0) begin
          in_data <= press_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
            gap_left = $urandom_range(0, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls on a rotating pattern.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaiting_results > 0) begin
          awaiting_results--;
        end
        if (predicted_reports.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("cycle %0d: result with nothing expected: press_event %0d evaluating %0d",
                     cycle_count, out_data.press_event, out_data.evaluating);
          end
        end else begin
          wanted = predicted_reports.pop_front();
          if (out_data.press_event !== wanted.press_event ||
              out_data.evaluating !== wanted.evaluating) begin
            error_count++;
            if (error_count <= 10) begin
              $display("cycle %0d: press_event exp %0d got %0d, evaluating exp %0d got %0d",
                       cycle_count, wanted.press_event, out_data.press_event,
                       wanted.evaluating, out_data.evaluating);
            end
          end
        end
      end
      case (cycle_count[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cycle_count[2:0] < 3'd5);
      endcase
    end
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed gestures at the reset settings.
    add_item(bpc_pkg::MODE_EDGE, 1'b0, 32'd50);          // age equal to debounce: dropped
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd60);          // timer stopped: ignored
    add_item(bpc_pkg::MODE_EDGE, 1'b1, 32'd52);          // release with timer stopped
    add_item(bpc_pkg::MODE_EVAL, 1'b1, 32'd60);
    add_item(bpc_pkg::MODE_EDGE, 1'b0, 32'd200);         // press starts the timer
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd210);
    add_item(bpc_pkg::MODE_EDGE, 1'b1, 32'd300);
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd310);         // short press counted
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd600);         // window not yet over
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd601);         // single
    add_item(bpc_pkg::MODE_EDGE, 1'b0, 32'd700);
    add_item(bpc_pkg::MODE_EDGE, 1'b1, 32'd720);         // bounce: dropped
    add_item(bpc_pkg::MODE_EDGE, 1'b1, 32'd800);
    add_item(bpc_pkg::MODE_EVAL, 1'b1, 32'd810);
    add_item(bpc_pkg::MODE_EDGE, 1'b0, 32'd900);
    add_item(bpc_pkg::MODE_EDGE, 1'b1, 32'd1000);
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd1010);
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd1400);        // double
    add_item(bpc_pkg::MODE_EDGE, 1'b0, 32'd2000);
    add_item(bpc_pkg::MODE_EDGE, 1'b1, 32'd3001);
    add_item(bpc_pkg::MODE_EVAL, 1'b0, 32'd3001);        // long
    add_item(bpc_pkg::MODE_EDGE, 1'b0, 32'hFFFF_FF00);   // press just before the wrap
    add_item(bpc_pkg::MODE_EDGE, 1'b1, 32'h0000_0100);
    add_item(bpc_pkg::MODE_EVAL, 1'b1, 32'h0000_0110);   // slow press: single
    wait_drained();

    fill_random(ITEMS_PER_PHASE);
    wait_drained();

    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    fill_random(ITEMS_PER_PHASE);
    wait_drained();

    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    fill_random(ITEMS_PER_PHASE);
    wait_drained();

    load_settings(16'd5, 16'd20, 16'd60, 16'd30, 1'b1);
    fill_random(ITEMS_PER_PHASE);
    wait_drained();

    for (int r = 0; r < 3; r++) begin
      load_settings(16'($urandom_range(0, (r == 2) ? 65535 : 200)),
                    16'($urandom_range(0, (r == 2) ? 65535 : 3000)),
                    16'($urandom_range(0, (r == 2) ? 65535 : 6000)),
                    16'($urandom_range(0, (r == 2) ? 65535 : 3000)),
                    1'($urandom_range(0, 1)));
      fill_random(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- button_press_classifier_core.f -----
+incdir+rtl
rtl/bpc_pkg.sv
rtl/button_press_classifier_core.sv
tb/tb_button_press_classifier_core.sv
